// ===== design/sszd_pkg.sv =====
// Shared types and constants for the seek steering zone detector.
// Used by every module of the block; no dependencies.
package sszd_pkg;

    localparam int POS_WIDTH_DEF = 24;

    localparam int RAD_W     = 23;                 // radius width, Q15.8 unsigned
    localparam int STR_W     = 16;                 // strength width, Q8.8
    localparam int MASK_W    = 4;
    localparam int MUL_W     = 25;                 // multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQ_W      = PROD_W + 1;         // sum of two squares
    localparam int ROOT_W    = MUL_W + 1;          // integer root of SQ_W bits
    localparam int QUO_W     = 17;                 // quotient width
    localparam int FRC_W     = 17;                 // force width, Q8.8 signed
    localparam int UW        = SQ_W + 1;           // root / divide datapath width
    localparam int CNT_W     = $clog2(ROOT_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = ((2 * FRC_W + 4 + 7) / 8) * 8;

    // event_mask bit positions
    localparam int EV_INNER_ENTER = 0;
    localparam int EV_INNER_EXIT  = 1;
    localparam int EV_OUTER_ENTER = 2;
    localparam int EV_OUTER_EXIT  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X     = 3'd0,
        REG_TARGET_Y     = 3'd1,
        REG_INNER_RADIUS = 3'd2,
        REG_OUTER_RADIUS = 3'd3,
        REG_STRENGTH     = 3'd4,
        REG_EVENT_MASK   = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_AX,
        ST_SQ_AY,
        ST_SQ_LX,
        ST_SQ_LY,
        ST_SQ_RI,
        ST_SQ_RO,
        ST_NORM,
        ST_DIR_Y,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_DIV_X,
        ST_DIV_X_WAIT,
        ST_DIV_Y,
        ST_DIV_Y_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== design/sszd_cfg.sv =====
// Configuration register file: target, radii, strength and event mask.
// Depends on sszd_pkg.
module sszd_cfg #(
    parameter int POS_WIDTH = sszd_pkg::POS_WIDTH_DEF,
    localparam int CFG_W = (POS_WIDTH > sszd_pkg::RAD_W) ? POS_WIDTH : sszd_pkg::RAD_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [sszd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    output logic [POS_WIDTH-1:0]            target_x,
    output logic [POS_WIDTH-1:0]            target_y,
    output logic [sszd_pkg::RAD_W-1:0]      inner_radius,
    output logic [sszd_pkg::RAD_W-1:0]      outer_radius,
    output logic [sszd_pkg::STR_W-1:0]      strength,
    output logic [sszd_pkg::MASK_W-1:0]     event_mask
);

    logic [POS_WIDTH-1:0]           target_x_reg;
    logic [POS_WIDTH-1:0]           target_y_reg;
    logic [sszd_pkg::RAD_W-1:0]     inner_radius_reg;
    logic [sszd_pkg::RAD_W-1:0]     outer_radius_reg;
    logic [sszd_pkg::STR_W-1:0]     strength_reg;
    logic [sszd_pkg::MASK_W-1:0]    event_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg     <= '0;
            target_y_reg     <= '0;
            inner_radius_reg <= '0;
            outer_radius_reg <= '0;
            strength_reg     <= '0;
            event_mask_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (sszd_pkg::cfg_idx_t'(cfg_index))
                sszd_pkg::REG_TARGET_X:     target_x_reg     <= cfg_data[POS_WIDTH-1:0];
                sszd_pkg::REG_TARGET_Y:     target_y_reg     <= cfg_data[POS_WIDTH-1:0];
                sszd_pkg::REG_INNER_RADIUS: inner_radius_reg <= cfg_data[sszd_pkg::RAD_W-1:0];
                sszd_pkg::REG_OUTER_RADIUS: outer_radius_reg <= cfg_data[sszd_pkg::RAD_W-1:0];
                sszd_pkg::REG_STRENGTH:     strength_reg     <= cfg_data[sszd_pkg::STR_W-1:0];
                sszd_pkg::REG_EVENT_MASK:   event_mask_reg   <= cfg_data[sszd_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign target_x     = target_x_reg;
    assign target_y     = target_y_reg;
    assign inner_radius = inner_radius_reg;
    assign outer_radius = outer_radius_reg;
    assign strength     = strength_reg;
    assign event_mask   = event_mask_reg;

endmodule

// ===== design/sszd_mul.sv =====
// Shared unsigned multiplier with registered product, loaded on issue.
// Depends on sszd_pkg.
module sszd_mul (
    input  logic                          clk,
    input  logic                          issue,
    input  logic [sszd_pkg::MUL_W-1:0]    mul_a,
    input  logic [sszd_pkg::MUL_W-1:0]    mul_b,
    output logic [sszd_pkg::PROD_W-1:0]   prod
);

    logic [sszd_pkg::PROD_W-1:0] prod_reg;

    // product holds until the next issue
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/sszd_rdiv.sv =====
// Bit-serial integer square root and restoring divider sharing one
// compare/subtract stage. Depends on sszd_pkg.
module sszd_rdiv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  sszd_pkg::op_t                   op,
    input  logic [sszd_pkg::UW-1:0]         opa,    // radicand or numerator
    input  logic [sszd_pkg::ROOT_W:0]       opb,    // divisor
    output logic                            done,
    output logic [sszd_pkg::ROOT_W-1:0]     result
);

    localparam int UW = sszd_pkg::UW;
    localparam int CNT_W = sszd_pkg::CNT_W;

    sszd_pkg::op_t      op_reg, op_next;
    logic [UW-1:0]      rem_reg, rem_next;
    logic [UW-1:0]      base_reg, base_next;
    logic [UW-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [UW-1:0]      trial;
    logic               ge;

    always_comb
    begin
        trial     = (op_reg == sszd_pkg::OP_SQRT) ? (acc_reg + base_reg) : base_reg;
        ge        = (rem_reg >= trial);
        op_next   = op_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            op_next   = op;
            rem_next  = opa;
            acc_next  = '0;
            busy_next = 1'b1;
            if (op == sszd_pkg::OP_SQRT)
            begin
                cnt_next  = CNT_W'(sszd_pkg::ROOT_W);
                base_next = UW'(1) << (2 * (sszd_pkg::ROOT_W - 1));
            end
            else
            begin
                cnt_next  = CNT_W'(sszd_pkg::QUO_W);
                base_next = UW'(opb) << (sszd_pkg::QUO_W - 1);
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - trial;
            end
            if (op_reg == sszd_pkg::OP_SQRT)
            begin
                acc_next  = (acc_reg >> 1) + (ge ? base_reg : '0);
                base_next = base_reg >> 2;
            end
            else
            begin
                acc_next  = {acc_reg[UW-2:0], ge};
                base_next = base_reg >> 1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= sszd_pkg::OP_SQRT;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg[sszd_pkg::ROOT_W-1:0];

endmodule

// ===== design/seek_steering_zone_detector.sv =====
// Seek steering zone detector, top level: sequencer, position state, output register.
// Depends on sszd_pkg, sszd_cfg, sszd_mul and sszd_rdiv.
//
// Usage: each transfer on s_axis carries the agent position. The block
// compares previous and current distance to the target with the inner and
// outer radius, and returns one m_axis transfer with the steering force
// (unit direction to the target times strength) and four masked zone flags.
// Configuration goes over the cfg channel (index, data); cfg_ready is always
// high, and registers should only be written while no item is in flight.
// An item's processing time is set by the shared restoring unit: a 26-step
// square root and, for a nonzero length, two 17-step divisions, fed by one
// 25x25 multiplier that computes eight squares and, for a nonzero length,
// the two strength products.
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register; a new item is taken while it waits, and the sequencer
// holds its finished result until that register is free.
// Reset clears all configuration, the previous position (to the origin) and
// the output valid.
module seek_steering_zone_detector #(
    parameter int POS_WIDTH = sszd_pkg::POS_WIDTH_DEF,
    localparam int CFG_W = (POS_WIDTH > sszd_pkg::RAD_W) ? POS_WIDTH : sszd_pkg::RAD_W,
    localparam int DIN_W = ((2 * POS_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [DIN_W-1:0]                s_axis_tdata,   // pos_x, pos_y
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // force_x, force_y, inner_enter, inner_exit, outer_enter, outer_exit
    output logic [sszd_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sszd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]                cfg_data
);

    localparam int AW     = POS_WIDTH + 1;
    localparam int MUL_W  = sszd_pkg::MUL_W;
    localparam int SQ_W   = sszd_pkg::SQ_W;
    localparam int UW     = sszd_pkg::UW;
    localparam int RAD_W  = sszd_pkg::RAD_W;
    localparam int ROOT_W = sszd_pkg::ROOT_W;
    localparam int QUO_W  = sszd_pkg::QUO_W;
    localparam int FRC_W  = sszd_pkg::FRC_W;
    localparam int OUT_W  = sszd_pkg::OUT_W;

    logic [POS_WIDTH-1:0]           target_x, target_y;
    logic [RAD_W-1:0]               inner_radius, outer_radius;
    logic [sszd_pkg::STR_W-1:0]     strength;
    logic [sszd_pkg::MASK_W-1:0]    event_mask;

    sszd_pkg::state_t               state_reg, state_next;
    logic [POS_WIDTH-1:0]           prev_x_reg, prev_y_reg;
    logic                           out_valid_reg;
    logic [OUT_W-1:0]               out_data_reg;

    logic [AW-1:0]                  ax_reg, ay_reg, lx_reg, ly_reg;
    logic                           neg_x_reg, neg_y_reg;
    logic [SQ_W-1:0]                acc_reg, was_reg;
    logic                           in_now_reg, in_was_reg, out_now_reg, out_was_reg;
    logic [ROOT_W-1:0]              len_reg;
    logic [QUO_W-1:0]               fx_reg, fy_reg;

    logic [POS_WIDTH-1:0]           pos_x, pos_y;
    logic [AW-1:0]                  dx_in, dy_in, ex_in, ey_in;
    logic [AW-1:0]                  ax_in, ay_in, lx_in, ly_in;
    logic                           a_small, l_small, dir_big;
    logic [SQ_W-1:0]                prod_ext, sum_acc, sum_was;
    logic [UW-1:0]                  div_num;
    logic [FRC_W-1:0]               force_x, force_y;
    logic                           inner_enter, inner_exit, outer_enter, outer_exit;
    logic                           take_in, out_load;

    logic                           mul_issue;
    logic [MUL_W-1:0]               mul_a, mul_b;
    logic [sszd_pkg::PROD_W-1:0]    prod;

    logic                           rd_start, rd_done;
    sszd_pkg::op_t                  rd_op;
    logic [UW-1:0]                  rd_a;
    logic [ROOT_W:0]                rd_b;
    logic [ROOT_W-1:0]              rd_res;

    sszd_cfg #(
        .POS_WIDTH (POS_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target_x     (target_x),
        .target_y     (target_y),
        .inner_radius (inner_radius),
        .outer_radius (outer_radius),
        .strength     (strength),
        .event_mask   (event_mask)
    );

    sszd_mul u_mul (
        .clk   (clk),
        .issue (mul_issue),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    sszd_rdiv u_rdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rd_start),
        .op     (rd_op),
        .opa    (rd_a),
        .opb    (rd_b),
        .done   (rd_done),
        .result (rd_res)
    );

    assign cfg_ready = 1'b1;

    // offsets to the target, one bit wider than a position
    assign pos_x = s_axis_tdata[POS_WIDTH-1:0];
    assign pos_y = s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
    assign dx_in = {target_x[POS_WIDTH-1], target_x} - {pos_x[POS_WIDTH-1], pos_x};
    assign dy_in = {target_y[POS_WIDTH-1], target_y} - {pos_y[POS_WIDTH-1], pos_y};
    assign ex_in = {target_x[POS_WIDTH-1], target_x} - {prev_x_reg[POS_WIDTH-1], prev_x_reg};
    assign ey_in = {target_y[POS_WIDTH-1], target_y} - {prev_y_reg[POS_WIDTH-1], prev_y_reg};
    assign ax_in = dx_in[AW-1] ? (~dx_in + 1'b1) : dx_in;
    assign ay_in = dy_in[AW-1] ? (~dy_in + 1'b1) : dy_in;
    assign lx_in = ex_in[AW-1] ? (~ex_in + 1'b1) : ex_in;
    assign ly_in = ey_in[AW-1] ? (~ey_in + 1'b1) : ey_in;

    // offsets beyond the radius range are never inside a zone
    assign a_small = ((ax_reg >> RAD_W) == '0) && ((ay_reg >> RAD_W) == '0);
    assign l_small = ((lx_reg >> RAD_W) == '0) && ((ly_reg >> RAD_W) == '0);
    assign dir_big = ((ax_reg >> MUL_W) != '0) || ((ay_reg >> MUL_W) != '0);

    assign prod_ext = SQ_W'(prod);
    assign sum_acc  = acc_reg + prod_ext;
    assign sum_was  = was_reg + prod_ext;
    assign div_num  = UW'({prod, 1'b0}) + UW'(len_reg);

    assign take_in       = s_axis_tvalid && (state_reg == sszd_pkg::ST_IDLE);
    assign s_axis_tready = (state_reg == sszd_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mul_issue  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        rd_start   = 1'b0;
        rd_op      = sszd_pkg::OP_SQRT;
        rd_a       = '0;
        rd_b       = '0;
        out_load   = 1'b0;
        case (state_reg)
            sszd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = sszd_pkg::ST_SQ_AX;
                end
            end
            sszd_pkg::ST_SQ_AX:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(RAD_W'(ax_reg));
                mul_b      = MUL_W'(RAD_W'(ax_reg));
                state_next = sszd_pkg::ST_SQ_AY;
            end
            sszd_pkg::ST_SQ_AY:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(RAD_W'(ay_reg));
                mul_b      = MUL_W'(RAD_W'(ay_reg));
                state_next = sszd_pkg::ST_SQ_LX;
            end
            sszd_pkg::ST_SQ_LX:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(RAD_W'(lx_reg));
                mul_b      = MUL_W'(RAD_W'(lx_reg));
                state_next = sszd_pkg::ST_SQ_LY;
            end
            sszd_pkg::ST_SQ_LY:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(RAD_W'(ly_reg));
                mul_b      = MUL_W'(RAD_W'(ly_reg));
                state_next = sszd_pkg::ST_SQ_RI;
            end
            sszd_pkg::ST_SQ_RI:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(inner_radius);
                mul_b      = MUL_W'(inner_radius);
                state_next = sszd_pkg::ST_SQ_RO;
            end
            sszd_pkg::ST_SQ_RO:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(outer_radius);
                mul_b      = MUL_W'(outer_radius);
                state_next = sszd_pkg::ST_NORM;
            end
            sszd_pkg::ST_NORM:
            begin
                // both offsets shift right together until they fit the multiplier
                if (!dir_big)
                begin
                    mul_issue  = 1'b1;
                    mul_a      = MUL_W'(ax_reg);
                    mul_b      = MUL_W'(ax_reg);
                    state_next = sszd_pkg::ST_DIR_Y;
                end
            end
            sszd_pkg::ST_DIR_Y:
            begin
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(ay_reg);
                mul_b      = MUL_W'(ay_reg);
                state_next = sszd_pkg::ST_ROOT;
            end
            sszd_pkg::ST_ROOT:
            begin
                rd_start   = 1'b1;
                rd_op      = sszd_pkg::OP_SQRT;
                rd_a       = UW'(sum_acc);
                state_next = sszd_pkg::ST_ROOT_WAIT;
            end
            sszd_pkg::ST_ROOT_WAIT:
            begin
                if (rd_done)
                begin
                    if (rd_res == '0)
                    begin
                        state_next = sszd_pkg::ST_OUT;
                    end
                    else
                    begin
                        mul_issue  = 1'b1;
                        mul_a      = MUL_W'(strength);
                        mul_b      = MUL_W'(ax_reg);
                        state_next = sszd_pkg::ST_DIV_X;
                    end
                end
            end
            sszd_pkg::ST_DIV_X:
            begin
                rd_start   = 1'b1;
                rd_op      = sszd_pkg::OP_DIV;
                rd_a       = div_num;
                rd_b       = {len_reg, 1'b0};
                mul_issue  = 1'b1;
                mul_a      = MUL_W'(strength);
                mul_b      = MUL_W'(ay_reg);
                state_next = sszd_pkg::ST_DIV_X_WAIT;
            end
            sszd_pkg::ST_DIV_X_WAIT:
            begin
                if (rd_done)
                begin
                    state_next = sszd_pkg::ST_DIV_Y;
                end
            end
            sszd_pkg::ST_DIV_Y:
            begin
                rd_start   = 1'b1;
                rd_op      = sszd_pkg::OP_DIV;
                rd_a       = div_num;
                rd_b       = {len_reg, 1'b0};
                state_next = sszd_pkg::ST_DIV_Y_WAIT;
            end
            sszd_pkg::ST_DIV_Y_WAIT:
            begin
                if (rd_done)
                begin
                    state_next = sszd_pkg::ST_OUT;
                end
            end
            sszd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = sszd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sszd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sszd_pkg::ST_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_in)
            begin
                prev_x_reg <= pos_x;
                prev_y_reg <= pos_y;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sszd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ax_reg    <= ax_in;
                    ay_reg    <= ay_in;
                    lx_reg    <= lx_in;
                    ly_reg    <= ly_in;
                    neg_x_reg <= dx_in[AW-1];
                    neg_y_reg <= dy_in[AW-1];
                end
            end
            sszd_pkg::ST_SQ_AY:
            begin
                acc_reg <= prod_ext;
            end
            sszd_pkg::ST_SQ_LX:
            begin
                acc_reg <= sum_acc;
            end
            sszd_pkg::ST_SQ_LY:
            begin
                was_reg <= prod_ext;
            end
            sszd_pkg::ST_SQ_RI:
            begin
                was_reg <= sum_was;
            end
            sszd_pkg::ST_SQ_RO:
            begin
                in_now_reg <= a_small && (acc_reg <= prod_ext);
                in_was_reg <= l_small && (was_reg <= prod_ext);
            end
            sszd_pkg::ST_NORM:
            begin
                out_now_reg <= a_small && (acc_reg <= prod_ext);
                out_was_reg <= l_small && (was_reg <= prod_ext);
                if (dir_big)
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
            end
            sszd_pkg::ST_DIR_Y:
            begin
                acc_reg <= prod_ext;
            end
            sszd_pkg::ST_ROOT_WAIT:
            begin
                if (rd_done)
                begin
                    len_reg <= rd_res;
                    fx_reg  <= '0;
                    fy_reg  <= '0;
                end
            end
            sszd_pkg::ST_DIV_X_WAIT:
            begin
                if (rd_done)
                begin
                    fx_reg <= rd_res[QUO_W-1:0];
                end
            end
            sszd_pkg::ST_DIV_Y_WAIT:
            begin
                if (rd_done)
                begin
                    fy_reg <= rd_res[QUO_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= OUT_W'({outer_exit, outer_enter, inner_exit, inner_enter,
                                    force_y, force_x});
        end
    end

    assign force_x = neg_x_reg ? (FRC_W'(0) - FRC_W'(fx_reg)) : FRC_W'(fx_reg);
    assign force_y = neg_y_reg ? (FRC_W'(0) - FRC_W'(fy_reg)) : FRC_W'(fy_reg);

    assign inner_enter = event_mask[sszd_pkg::EV_INNER_ENTER] && !in_was_reg && in_now_reg;
    assign inner_exit  = event_mask[sszd_pkg::EV_INNER_EXIT] && in_was_reg && !in_now_reg;
    assign outer_enter = event_mask[sszd_pkg::EV_OUTER_ENTER] && !out_was_reg && out_now_reg;
    assign outer_exit  = event_mask[sszd_pkg::EV_OUTER_EXIT] && out_was_reg && !out_now_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== test/steer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the seek steering zone detector: follows cfg, s_axis and m_axis,
// predicts force and zone flags per position, compares every m_axis transfer.
// Depends on sszd_pkg.
module steer_checker
    import sszd_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [((2 * POS_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // pos_x, pos_y
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // force_x, force_y, inner_enter, inner_exit, outer_enter, outer_exit
    input  logic [OUT_W-1:0]          m_axis_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [((POS_WIDTH > RAD_W) ? POS_WIDTH : RAD_W) - 1:0] cfg_data,
    output int                        errors,
    output int                        outstanding
);

    localparam int FLAG_LSB = 2 * FRC_W;
    localparam int DIR_BITS = 25;
    localparam longint unsigned RAD_MAX = (64'd1 << RAD_W) - 1;
    localparam longint unsigned DIR_LIM = 64'd1 << DIR_BITS;

    typedef logic signed [POS_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic signed [FRC_W-1:0] force_x;
        logic signed [FRC_W-1:0] force_y;
        logic                    inner_enter;
        logic                    inner_exit;
        logic                    outer_enter;
        logic                    outer_exit;
    } steer_t;

    coord_t            aim_x, aim_y;
    coord_t            last_x, last_y;
    logic [RAD_W-1:0]  inner_r, outer_r;
    logic [STR_W-1:0]  thrust;
    logic [MASK_W-1:0] flag_en;
    steer_t            pending_steers[$];
    steer_t            got, want;

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        $display("%0t: %s got %0d, expected %0d", $time, what, got_v, want_v);
        errors = errors + 1;
    endtask

    function automatic bit within_radius(input longint unsigned ax, input longint unsigned ay,
                                         input logic [RAD_W-1:0] r);
        longint unsigned rr;
        rr = r;
        if (ax > RAD_MAX || ay > RAD_MAX)
            return 1'b0;
        return (ax * ax + ay * ay) <= rr * rr;
    endfunction

    // bitwise floor square root; the sum of squares stays below 2^51
    function automatic longint unsigned floor_root(input longint unsigned s);
        longint unsigned r, t;
        r = 0;
        for (int b = 26; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic steer_t predict_steering(input coord_t px, input coord_t py);
        longint            dx, dy;
        longint unsigned   ax, ay, lx, ly, sx, sy, len, fx, fy, str;
        bit                in_was, in_now, out_was, out_now;
        logic [FRC_W-1:0]  mx, my;
        steer_t            res;
        dx = longint'(aim_x) - longint'(px);
        dy = longint'(aim_y) - longint'(py);
        ax = magnitude(dx);
        ay = magnitude(dy);
        lx = magnitude(longint'(aim_x) - longint'(last_x));
        ly = magnitude(longint'(aim_y) - longint'(last_y));
        in_was  = within_radius(lx, ly, inner_r);
        in_now  = within_radius(ax, ay, inner_r);
        out_was = within_radius(lx, ly, outer_r);
        out_now = within_radius(ax, ay, outer_r);
        // scale both offsets down together until each fits the direction datapath
        sx = ax;
        sy = ay;
        while (sx >= DIR_LIM || sy >= DIR_LIM)
        begin
            sx = sx >> 1;
            sy = sy >> 1;
        end
        len = floor_root(sx * sx + sy * sy);
        str = thrust;
        fx = 0;
        fy = 0;
        if (len != 0)
        begin
            fx = (2 * str * sx + len) / (2 * len);
            fy = (2 * str * sy + len) / (2 * len);
        end
        mx = fx[FRC_W-1:0];
        my = fy[FRC_W-1:0];
        res.force_x     = (dx < 0) ? -mx : mx;
        res.force_y     = (dy < 0) ? -my : my;
        res.inner_enter = flag_en[EV_INNER_ENTER] && !in_was && in_now;
        res.inner_exit  = flag_en[EV_INNER_EXIT] && in_was && !in_now;
        res.outer_enter = flag_en[EV_OUTER_ENTER] && !out_was && out_now;
        res.outer_exit  = flag_en[EV_OUTER_EXIT] && out_was && !out_now;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aim_x   = '0;
            aim_y   = '0;
            last_x  = '0;
            last_y  = '0;
            inner_r = '0;
            outer_r = '0;
            thrust  = '0;
            flag_en = '0;
            errors  = 0;
            pending_steers.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_TARGET_X:     aim_x   = cfg_data[POS_WIDTH-1:0];
                    REG_TARGET_Y:     aim_y   = cfg_data[POS_WIDTH-1:0];
                    REG_INNER_RADIUS: inner_r = cfg_data[RAD_W-1:0];
                    REG_OUTER_RADIUS: outer_r = cfg_data[RAD_W-1:0];
                    REG_STRENGTH:     thrust  = cfg_data[STR_W-1:0];
                    REG_EVENT_MASK:   flag_en = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a transfer with nothing waiting cannot match a new entry
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.force_x     = m_axis_tdata[FRC_W-1:0];
                got.force_y     = m_axis_tdata[2*FRC_W-1:FRC_W];
                got.inner_enter = m_axis_tdata[FLAG_LSB + EV_INNER_ENTER];
                got.inner_exit  = m_axis_tdata[FLAG_LSB + EV_INNER_EXIT];
                got.outer_enter = m_axis_tdata[FLAG_LSB + EV_OUTER_ENTER];
                got.outer_exit  = m_axis_tdata[FLAG_LSB + EV_OUTER_EXIT];
                if (pending_steers.size() == 0)
                    report_mismatch("result transfer with nothing expected", 0, 0);
                else
                begin
                    want = pending_steers.pop_front();
                    if (got.force_x !== want.force_x)
                        report_mismatch("force_x", got.force_x, want.force_x);
                    if (got.force_y !== want.force_y)
                        report_mismatch("force_y", got.force_y, want.force_y);
                    if (got.inner_enter !== want.inner_enter)
                        report_mismatch("inner_enter", got.inner_enter, want.inner_enter);
                    if (got.inner_exit !== want.inner_exit)
                        report_mismatch("inner_exit", got.inner_exit, want.inner_exit);
                    if (got.outer_enter !== want.outer_enter)
                        report_mismatch("outer_enter", got.outer_enter, want.outer_enter);
                    if (got.outer_exit !== want.outer_exit)
                        report_mismatch("outer_exit", got.outer_exit, want.outer_exit);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_steers.push_back(predict_steering(s_axis_tdata[POS_WIDTH-1:0],
                                                          s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]));
                last_x = s_axis_tdata[POS_WIDTH-1:0];
                last_y = s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
            end
            outstanding <= pending_steers.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the seek steering zone detector: clock, reset, register
// writes, position stimulus, result pacing and the verdict.
// Depends on sszd_pkg, seek_steering_zone_detector and steer_checker.
module tb;
    import sszd_pkg::*;

    localparam int POS_W         = POS_WIDTH_DEF;
    localparam int CFG_W         = (POS_W > RAD_W) ? POS_W : RAD_W;
    localparam int DIN_W         = ((2 * POS_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = 150;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 52;
    localparam int PRESSURE_PH   = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef logic signed [POS_W-1:0] coord_t;

    localparam coord_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam coord_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam coord_t ONE     = 256;  // 1.0 in Q15.8

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DIN_W-1:0]     s_axis_tdata = '0;   // pos_x, pos_y
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // force_x, force_y, inner_enter, inner_exit, outer_enter, outer_exit
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int errors;
    int outstanding;
    int cycle_count = 0;
    bit quiet = 1'b0;
    bit hold_out = 1'b0;

    // stimulus side copy of the zone setup, used to aim positions near the edges
    coord_t           aim_x, aim_y;
    logic [RAD_W-1:0] ring_in, ring_out;

    always #2 clk = ~clk;

    seek_steering_zone_detector #(.POS_WIDTH(POS_W)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    steer_checker #(.POS_WIDTH(POS_W)) u_steer_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pos(input coord_t x, input coord_t y);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // stop offering and wait until every transfer has its result back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 5))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return '0;
            default: return coord_t'($urandom());
        endcase
    endfunction

    task automatic load_zone_setup(input coord_t tx, input coord_t ty,
                                   input logic [CFG_W-1:0] inner, input logic [CFG_W-1:0] outer,
                                   input logic [CFG_W-1:0] str, input logic [CFG_W-1:0] mask);
        aim_x    = tx;
        aim_y    = ty;
        ring_in  = inner[RAD_W-1:0];
        ring_out = outer[RAD_W-1:0];
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_INNER_RADIUS, inner);
        write_reg(REG_OUTER_RADIUS, outer);
        write_reg(REG_STRENGTH, str);
        write_reg(REG_EVENT_MASK, mask);
    endtask

    // random setup; upper bits of the write data carry junk that must be dropped
    task automatic load_random_setup();
        logic [CFG_W-1:0]  junk;
        logic [RAD_W-1:0]  r_in, r_out;
        logic [STR_W-1:0]  str;
        logic [MASK_W-1:0] mask;
        int                e;
        junk = $urandom();
        e = $urandom_range(0, RAD_W);
        r_out = (e == RAD_W) ? '1 : RAD_W'($urandom_range(0, (1 << e) - 1));
        if ($urandom_range(0, 5) == 0)
            r_in = RAD_W'($urandom());
        else
            r_in = RAD_W'($urandom_range(0, r_out));
        case ($urandom_range(0, 4))
            0:       str = '0;
            1:       str = '1;
            default: str = STR_W'($urandom());
        endcase
        mask = ($urandom_range(0, 1) == 0) ? '1 : MASK_W'($urandom());
        load_zone_setup(pick_coord(), pick_coord(),
                        {junk[CFG_W-1:RAD_W], r_in}, {junk[CFG_W-1:RAD_W], r_out},
                        {junk[CFG_W-1:STR_W], str}, {junk[CFG_W-1:MASK_W], mask});
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                      CFG_W'($urandom()));
    endtask

    // mostly positions around the zone edges so enter and exit events keep happening
    task automatic send_random_pos();
        longint span, ox, oy;
        coord_t x, y;
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                x = coord_t'($urandom());
                y = coord_t'($urandom());
            end
            3:
            begin
                x = aim_x;
                y = aim_y;
            end
            4:
            begin
                ox = ($urandom_range(0, 1) == 0) ? longint'(ring_in) : longint'(ring_out);
                x = coord_t'(longint'(aim_x) + ox + $urandom_range(0, 1));
                y = aim_y;
            end
            default:
            begin
                span = 2 * longint'(ring_out) + 64;
                ox = longint'($urandom_range(0, 2 * span)) - span;
                oy = longint'($urandom_range(0, 2 * span)) - span;
                x = coord_t'(longint'(aim_x) + ox);
                y = coord_t'(longint'(aim_y) + oy);
            end
        endcase
        send_pos(x, y);
    endtask

    // result side: random ready gaps, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: mask clear, strength zero; first item sits on the origin
        send_pos('0, '0);
        send_pos(POS_MAX, POS_MIN);
        drain();

        // target at origin, inner 10.0, outer 50.0, strength 1.0, all flags on
        load_zone_setup('0, '0, 10 * ONE, 50 * ONE, ONE, MASK_W'('1));
        send_pos(100 * ONE, '0);
        send_pos(40 * ONE, '0);
        send_pos(10 * ONE, '0);             // exactly on the inner edge counts as inside
        send_pos('0, '0);                   // on target: zero length, zero force
        send_pos(10 * ONE + 1, '0);
        send_pos(6 * ONE, 8 * ONE);         // diagonal, exactly on the inner edge
        send_pos(50 * ONE + 1, '0);
        send_pos(-50 * ONE, '0);
        send_pos(POS_MIN, POS_MIN);
        send_pos(POS_MAX, POS_MAX);
        send_pos(POS_MAX, POS_MIN);
        drain();

        // corner target, full inner radius, zero outer radius, full strength,
        // only the enter flags on; the spare indexes must not disturb anything
        load_zone_setup(POS_MIN, POS_MAX, '1, {1'b1, {(CFG_W-1){1'b0}}}, '1,
                        {{(CFG_W-MASK_W){1'b1}}, 4'b0101});
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '0);
        send_pos(POS_MIN, POS_MAX);
        send_pos(POS_MIN + 1, POS_MAX);
        send_pos(POS_MAX, POS_MIN);
        send_pos(POS_MIN, POS_MAX - 1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_random_setup();
            quiet = (ph % 4 == 1) || (ph == PRESSURE_PH);
            if (ph == PRESSURE_PH)
                hold_out = 1'b1;
            repeat (PHASE_ITEMS) send_random_pos();
            drain();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sszd_pkg.sv
design/sszd_cfg.sv
design/sszd_mul.sv
design/sszd_rdiv.sv
design/seek_steering_zone_detector.sv
test/steer_checker.sv
test/tb.sv
